/* rtl/core/osa_pkg.sv */
// ----------------------------------------------------------------------------
// osa_pkg
// Shared types and constants for the ordered slot allocator: request and
// status codes, controller states and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned LINK_W   = $clog2(CAPACITY + 1);
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STAT_W   = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ROTATE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_SW_B,
    S_SW_W,
    S_ROT_A,
    S_SHIFT,
    S_ROT_T,
    S_DONE
  } osa_state_e;

  // order list read address source
  typedef enum logic [2:0] {
    RD_PA_IN,
    RD_ZERO,
    RD_PB,
    RD_IDX1,
    RD_IDX2
  } rd_sel_e;

  // order list write address/data source
  typedef enum logic [1:0] {
    WR_PA_RD,
    WR_PB_TMP,
    WR_IDX_RD,
    WR_LAST_TMP
  } wr_sel_e;

  typedef struct packed {
    logic    cap_req;       // latch request fields, preset result
    logic    do_add;        // pop free head, append to order list
    rd_sel_e rd_sel;
    logic    res_rd;        // result slot from read data
    logic    tmp_ld;
    logic    release_slot;  // push read slot on free list, occupancy - 1
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_inc;
  } cmd_t;

  typedef struct packed {
    logic err;       // incoming request fails its guard
    logic lt1;       // idx + 1 < occupancy
    logic lt2;       // idx + 2 < occupancy
    logic idx_zero;
  } stat_t;

endpackage

/* rtl/core/ordered_slot_allocator.sv */
// ----------------------------------------------------------------------------
// ordered_slot_allocator
// Fixed pool of slots with a linked free list and an order list of occupied
// slots; add, remove, swap, rotate and lookup, one result per request.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, req_type_i,       | in
//          | position_a_i, position_b_i                |
//  out     | out_valid_o, out_stall_i, slot_o,         | out
//          | count_o, status_o                         |
//
//  One request at a time; the result is offered the cycle after the last
//  step. Add and any guard failure go straight to the result; lookup
//  reads one entry, swap reads and writes both positions. Remove and rotate
//  can also shift the order list, one entry per cycle through its single
//  read and write port. Reset is asynchronous, active low; no clearing pass.
//  A stalled result holds the block until it is transferred.
// ----------------------------------------------------------------------------
module ordered_slot_allocator
  import osa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [POS_W-1:0]  position_a_i,
  input  logic [POS_W-1:0]  position_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [STAT_W-1:0] status_o
);

  cmd_t  cmd;
  stat_t stat;

  osa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .req_type_i  (req_type_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  osa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .position_a_i (position_a_i),
    .position_b_i (position_b_i),
    .slot_o       (slot_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  // a pending result blocks new requests
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (count_o == CNT_W'(CAPACITY)))
    else $error("pool full reported below capacity");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(count_o)))
    else $error("stalled result changed");

endmodule

/* rtl/core/osa_datapath.sv */
// ----------------------------------------------------------------------------
// osa_datapath
// Free list, order list memory, occupancy, request guards and result
// registers. Driven one micro-step per cycle by the controller.
// ----------------------------------------------------------------------------
module osa_datapath
  import osa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [POS_W-1:0]  position_a_i,
  input  logic [POS_W-1:0]  position_b_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [STAT_W-1:0] status_o
);

  logic [LINK_W-1:0] link_q [CAPACITY];
  logic [LINK_W-1:0] head_q;
  logic [CNT_W-1:0]  occ_q;
  logic [SLOT_W-1:0] order_mem [CAPACITY];
  logic [SLOT_W-1:0] rd_q;
  logic [SLOT_W-1:0] tmp_q;
  logic [POS_W-1:0]  pa_q, pb_q, idx_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [STAT_W-1:0] res_status_q;

  logic [STAT_W-1:0] err_code;
  logic              err;
  logic [CNT_W-1:0]  pa_ext, pb_ext, idx_ext;
  logic [POS_W-1:0]  mem_ra, mem_wa;
  logic [SLOT_W-1:0] mem_wd;
  logic              mem_we;

  assign pa_ext  = CNT_W'(position_a_i);
  assign pb_ext  = CNT_W'(position_b_i);
  assign idx_ext = CNT_W'(idx_q);

  // request guards
  always_comb begin
    err      = 1'b0;
    err_code = ST_BAD;
    case (req_type_i)
      REQ_ADD: begin
        err      = (occ_q >= CNT_W'(CAPACITY)) || (head_q >= LINK_W'(CAPACITY));
        err_code = ST_FULL;
      end
      REQ_REMOVE, REQ_LOOKUP: err = (pa_ext >= occ_q);
      REQ_SWAP:               err = (pa_ext >= occ_q) || (pb_ext >= occ_q);
      REQ_ROTATE:             err = (occ_q == '0);
      default:                err = 1'b1;
    endcase
  end

  assign stat_o.err      = err;
  assign stat_o.lt1      = (idx_ext + CNT_W'(1)) < occ_q;
  assign stat_o.lt2      = (idx_ext + CNT_W'(2)) < occ_q;
  assign stat_o.idx_zero = (idx_q == '0);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PA_IN: mem_ra = position_a_i;
      RD_ZERO:  mem_ra = '0;
      RD_PB:    mem_ra = pb_q;
      RD_IDX1:  mem_ra = idx_q + POS_W'(1);
      RD_IDX2:  mem_ra = idx_q + POS_W'(2);
      default:  mem_ra = '0;
    endcase
  end

  always_comb begin
    mem_we = cmd_i.wr_en || cmd_i.do_add;
    if (cmd_i.do_add) begin
      mem_wa = occ_q[POS_W-1:0];
      mem_wd = head_q[SLOT_W-1:0];
    end else begin
      case (cmd_i.wr_sel)
        WR_PA_RD: begin
          mem_wa = pa_q;
          mem_wd = rd_q;
        end
        WR_PB_TMP: begin
          mem_wa = pb_q;
          mem_wd = tmp_q;
        end
        WR_IDX_RD: begin
          mem_wa = idx_q;
          mem_wd = rd_q;
        end
        WR_LAST_TMP: begin
          mem_wa = POS_W'(occ_q - CNT_W'(1));
          mem_wd = tmp_q;
        end
        default: begin
          mem_wa = idx_q;
          mem_wd = rd_q;
        end
      endcase
    end
  end

  // order list: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      order_mem[mem_wa] <= mem_wd;
    end
    rd_q <= order_mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      pa_q         <= position_a_i;
      pb_q         <= position_b_i;
      idx_q        <= (req_type_i == REQ_ROTATE) ? '0 : position_a_i;
      // add reports the popped head in the same cycle
      res_slot_q   <= cmd_i.do_add ? head_q[SLOT_W-1:0] : '0;
      res_status_q <= err ? err_code : ST_OK;
    end
    if (cmd_i.idx_inc) begin
      idx_q <= idx_q + POS_W'(1);
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rd_q;
    end
    if (cmd_i.res_rd) begin
      res_slot_q <= rd_q;
    end
  end

  // free list and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        link_q[i] <= LINK_W'(i + 1);
      end
      head_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.do_add) begin
      head_q <= link_q[head_q[SLOT_W-1:0]];
      occ_q  <= occ_q + CNT_W'(1);
    end else if (cmd_i.release_slot) begin
      link_q[rd_q] <= head_q;
      head_q       <= LINK_W'(rd_q);
      occ_q        <= occ_q - CNT_W'(1);
    end
  end

  assign slot_o   = res_slot_q;
  assign count_o  = occ_q;
  assign status_o = res_status_q;

endmodule

/* rtl/core/osa_ctrl.sv */
// ----------------------------------------------------------------------------
// osa_ctrl
// Request sequencer: steps the datapath through the reads, writes and the
// order list shift of each request, then holds the result for transfer.
// ----------------------------------------------------------------------------
module osa_ctrl
  import osa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  stat_t            stat_i,
  output cmd_t             cmd_o
);

  osa_state_e       state_q, state_d;
  logic [REQ_W-1:0] req_q;
  logic             accept;

  assign accept = (state_q == S_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= REQ_ADD;
    end else begin
      state_q <= state_d;
      if (accept) begin
        req_q <= req_type_i;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.err) begin
            state_d = S_DONE;
          end else begin
            case (req_type_i)
              REQ_REMOVE, REQ_LOOKUP, REQ_SWAP: state_d = S_RD_A;
              REQ_ROTATE:                       state_d = S_ROT_A;
              default:                          state_d = S_DONE;
            endcase
          end
        end
      end
      S_RD_A: begin
        case (req_q)
          REQ_SWAP:   state_d = S_SW_B;
          REQ_REMOVE: state_d = stat_i.lt1 ? S_SHIFT : S_DONE;
          default:    state_d = S_DONE;
        endcase
      end
      S_SW_B:  state_d = S_SW_W;
      S_SW_W:  state_d = S_DONE;
      S_ROT_A: state_d = stat_i.lt1 ? S_SHIFT : S_DONE;
      S_SHIFT: begin
        if (req_q == REQ_ROTATE) begin
          state_d = stat_i.lt2 ? S_SHIFT : S_ROT_T;
        end else begin
          state_d = stat_i.lt1 ? S_SHIFT : S_DONE;
        end
      end
      S_ROT_T: state_d = S_DONE;
      S_DONE:  state_d = out_stall_i ? S_DONE : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_ZERO;
    cmd_o.wr_sel = WR_IDX_RD;
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.cap_req = in_valid_i;
        cmd_o.rd_sel  = (req_type_i == REQ_ROTATE) ? RD_ZERO : RD_PA_IN;
        cmd_o.do_add  = in_valid_i && !stat_i.err && (req_type_i == REQ_ADD);
      end
      S_RD_A: begin
        case (req_q)
          REQ_SWAP: begin
            cmd_o.tmp_ld = 1'b1;
            cmd_o.rd_sel = RD_PB;
          end
          REQ_REMOVE: begin
            cmd_o.res_rd       = 1'b1;
            cmd_o.release_slot = 1'b1;
            cmd_o.rd_sel       = RD_IDX1;
          end
          default: cmd_o.res_rd = 1'b1;
        endcase
      end
      S_SW_B: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PA_RD;
        cmd_o.res_rd = 1'b1;
      end
      S_SW_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PB_TMP;
      end
      S_ROT_A: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.res_rd = 1'b1;
        cmd_o.rd_sel = RD_IDX1;
      end
      S_SHIFT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_IDX_RD;
        cmd_o.idx_inc = 1'b1;
        cmd_o.rd_sel  = RD_IDX2;
        // rotate: the entry moved into position 0 is the new first slot
        cmd_o.res_rd  = (req_q == REQ_ROTATE) && stat_i.idx_zero;
      end
      S_ROT_T: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LAST_TMP;
      end
      S_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
